// File: rtl/core/atam_pkg.sv
// Package for the affine texel address mapper: widths, register indexes,
// wrap codes and the pipeline record. No dependencies.
package atam_pkg;
    localparam int TEXTURE_MAX = 1024;
    localparam int SCREEN_MAX  = 1024;
    localparam int SIZE_W      = 11;
    localparam int COORD_W     = 10;
    localparam int OFF_W       = 18;
    localparam int PROD_W      = 34;
    localparam int SUM_W       = 36;
    localparam int SRC_W       = 28;
    localparam int MOD_STAGES  = 4;
    localparam int MOD_STEPS   = SRC_W / MOD_STAGES;
    localparam int PIPE_DEPTH  = 4 + MOD_STAGES;

    localparam logic [2:0] REG_MATRIX_AB = 3'd0;
    localparam logic [2:0] REG_MATRIX_CD = 3'd1;
    localparam logic [2:0] REG_SCROLL_HV = 3'd2;
    localparam logic [2:0] REG_CENTER_XY = 3'd3;
    localparam logic [2:0] REG_ORIGIN_XY = 3'd4;
    localparam logic [2:0] REG_TEX_SIZE  = 3'd5;
    localparam logic [2:0] REG_WRAP_MODE = 3'd6;

    localparam logic [1:0] WRAP_NONE   = 2'd0;
    localparam logic [1:0] WRAP_CLAMP  = 2'd1;
    localparam logic [1:0] WRAP_REPEAT = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0]  rem_x;
        logic [SIZE_W-1:0]  rem_y;
        logic [SRC_W-1:0]   mag_x;
        logic [SRC_W-1:0]   mag_y;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               phit;
    } mod_t;
endpackage

// File: rtl/core/affine_texel_address_mapper.sv
// Top level of the affine texel address mapper: offset, matrix multiply,
// truncation, wrap and a pipelined remainder unit. Depends on atam_pkg.
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: dest_x, dest_y
// m_axis    out  tvalid/tready         tdata: src_x, src_y; tuser: hit
// cfg       in   cfg_we                cfg_index, cfg_data
//
// Eight register stages, one item per cycle unless stalled. The depth is set
// by the offset, the multiply, the sum and the 28-step restoring remainder
// used for repeat wrap (seven steps per stage). Reset clears valid bits and
// loads register defaults. A stall at the output freezes the whole pipeline.
module affine_texel_address_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // dest_x[9:0], dest_y[19:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // src_x[9:0], src_y[19:10]
    output logic [0:0]  m_axis_tuser    // hit[0]
);
    import atam_pkg::*;

    logic [31:0] ab_reg, cd_reg, hv_reg, cxy_reg, oxy_reg;
    logic [21:0] size_reg;
    logic [1:0]  wrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ab_reg   <= 32'h0100_0000;
            cd_reg   <= 32'h0000_0100;
            hv_reg   <= '0;
            cxy_reg  <= '0;
            oxy_reg  <= '0;
            size_reg <= 22'd524544;
            wrap_reg <= WRAP_NONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_AB: ab_reg   <= cfg_data;
                REG_MATRIX_CD: cd_reg   <= cfg_data;
                REG_SCROLL_HV: hv_reg   <= cfg_data;
                REG_CENTER_XY: cxy_reg  <= cfg_data;
                REG_ORIGIN_XY: oxy_reg  <= cfg_data;
                REG_TEX_SIZE:  size_reg <= cfg_data[21:0];
                REG_WRAP_MODE: wrap_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [SIZE_W-1:0] sat_size(input logic [10:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0)
            r = SIZE_W'(1);
        else if (s > 11'(TEXTURE_MAX))
            r = SIZE_W'(TEXTURE_MAX);
        else
            r = s;
        return r;
    endfunction

    function automatic mod_t mod_steps(input mod_t m, input logic [SIZE_W-1:0] w,
                                       input logic [SIZE_W-1:0] h);
        mod_t r;
        logic [SIZE_W:0] tx, ty;
        r = m;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            tx = {r.rem_x, r.mag_x[SRC_W-1]};
            ty = {r.rem_y, r.mag_y[SRC_W-1]};
            if (tx >= {1'b0, w})
                tx = tx - {1'b0, w};
            if (ty >= {1'b0, h})
                ty = ty - {1'b0, h};
            r.rem_x = tx[SIZE_W-1:0];
            r.rem_y = ty[SIZE_W-1:0];
            r.mag_x = {r.mag_x[SRC_W-2:0], 1'b0};
            r.mag_y = {r.mag_y[SRC_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic signed [15:0] ca, cb, cc, cd, ch, cv, ccx, ccy, cox, coy;
    logic [SIZE_W-1:0]  tex_w, tex_h;
    assign ca  = ab_reg[31:16];
    assign cb  = ab_reg[15:0];
    assign cc  = cd_reg[31:16];
    assign cd  = cd_reg[15:0];
    assign ch  = hv_reg[31:16];
    assign cv  = hv_reg[15:0];
    assign ccx = cxy_reg[31:16];
    assign ccy = cxy_reg[15:0];
    assign cox = oxy_reg[31:16];
    assign coy = oxy_reg[15:0];
    assign tex_w = sat_size(size_reg[21:11]);
    assign tex_h = sat_size(size_reg[10:0]);

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [OFF_W-1:0]  xi_reg, yi_reg, xi_next, yi_next;
    logic signed [PROD_W-1:0] pax_reg, pby_reg, pcx_reg, pdy_reg;
    logic signed [SRC_W-1:0]  sx_reg, sy_reg, sx_next, sy_next;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    mod_t                     init_next;
    mod_t                     mod_reg [MOD_STAGES+1];

    always_comb
    begin
        xi_next = OFF_W'($signed({1'b0, s_axis_tdata[9:0]})) - OFF_W'(cox)
                  + OFF_W'(ch) - OFF_W'(ccx);
        yi_next = OFF_W'($signed({1'b0, s_axis_tdata[19:10]})) - OFF_W'(coy)
                  + OFF_W'(cv) - OFF_W'(ccy);
        sum_x = SUM_W'(pax_reg) + SUM_W'(pby_reg) + SUM_W'($signed({ccx, 8'h00}));
        sum_y = SUM_W'(pcx_reg) + SUM_W'(pdy_reg) + SUM_W'($signed({ccy, 8'h00}));
        if (sum_x < 0)
            sum_x = sum_x + SUM_W'(255);
        if (sum_y < 0)
            sum_y = sum_y + SUM_W'(255);
        sx_next = sum_x[SUM_W-1:8];
        sy_next = sum_y[SUM_W-1:8];
    end

    always_comb
    begin
        init_next.rem_x = '0;
        init_next.rem_y = '0;
        init_next.mag_x = sx_reg[SRC_W-1] ? SRC_W'(-sx_reg) : SRC_W'(sx_reg);
        init_next.mag_y = sy_reg[SRC_W-1] ? SRC_W'(-sy_reg) : SRC_W'(sy_reg);
        init_next.phit  = 1'b1;
        init_next.px    = sx_reg[COORD_W-1:0];
        init_next.py    = sy_reg[COORD_W-1:0];
        if (wrap_reg == WRAP_CLAMP)
        begin
            if (sx_reg < 0)
                init_next.px = '0;
            else if (sx_reg > SRC_W'(tex_w) - SRC_W'(1))
                init_next.px = COORD_W'(tex_w - SIZE_W'(1));
            if (sy_reg < 0)
                init_next.py = '0;
            else if (sy_reg > SRC_W'(tex_h) - SRC_W'(1))
                init_next.py = COORD_W'(tex_h - SIZE_W'(1));
        end
        else if (wrap_reg != WRAP_REPEAT)
        begin
            if (sx_reg < 0 || sx_reg > SRC_W'(tex_w) - SRC_W'(1)
                || sy_reg < 0 || sy_reg > SRC_W'(tex_h) - SRC_W'(1))
            begin
                init_next.phit = 1'b0;
                init_next.px   = '0;
                init_next.py   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xi_reg  <= xi_next;
            yi_reg  <= yi_next;
            pax_reg <= ca * xi_reg;
            pby_reg <= cb * yi_reg;
            pcx_reg <= cc * xi_reg;
            pdy_reg <= cd * yi_reg;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            mod_reg[0] <= init_next;
            for (int k = 1; k <= MOD_STAGES; k++)
                mod_reg[k] <= mod_steps(mod_reg[k-1], tex_w, tex_h);
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    always_comb
    begin
        m_axis_tdata = '0;
        if (wrap_reg == WRAP_REPEAT)
        begin
            m_axis_tdata[9:0]   = mod_reg[MOD_STAGES].rem_x[COORD_W-1:0];
            m_axis_tdata[19:10] = mod_reg[MOD_STAGES].rem_y[COORD_W-1:0];
            m_axis_tuser        = 1'b1;
        end
        else
        begin
            m_axis_tdata[9:0]   = mod_reg[MOD_STAGES].px;
            m_axis_tdata[19:10] = mod_reg[MOD_STAGES].py;
            m_axis_tuser        = mod_reg[MOD_STAGES].phit;
        end
    end
endmodule

// File: bench/affine_texel_address_mapper_tb.sv
// Testbench for affine_texel_address_mapper: random and directed pixels under
// several register settings, checked against an in-bench mapping predictor.
// Depends on atam_pkg and the mapper RTL.
module affine_texel_address_mapper_tb;
    import atam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [9:0] y;
        logic [9:0] x;
    } pixel_t;

    typedef struct packed {
        logic [9:0] sx;
        logic [9:0] sy;
        logic       hit;
    } texel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_MATRIX_AB;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    logic [31:0] mat_ab, mat_cd, scroll, center, origin;
    logic [21:0] tex_size;
    logic [1:0]  wrap;

    pixel_t pending_pixels[$];
    texel_t expected_texels[$];
    int     errors = 0;
    int     in_gap = 0;
    int     out_gap = 0;
    bit     calm = 1'b0;

    affine_texel_address_mapper dut (.*);

    always #2 clk = ~clk;

    function automatic longint s16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clip_size(logic [10:0] s);
        if (s == 0) return 1;
        if (s > TEXTURE_MAX) return TEXTURE_MAX;
        return longint'(s);
    endfunction

    function automatic longint fold(longint s, longint n, logic [1:0] m, ref bit in_tex);
        if (m == WRAP_REPEAT) return (s < 0 ? -s : s) % n;
        if (m == WRAP_CLAMP) return s < 0 ? 0 : (s > n - 1 ? n - 1 : s);
        if (s < 0 || s > n - 1) in_tex = 1'b0;
        return s;
    endfunction

    function automatic texel_t map_pixel(pixel_t p);
        longint xi, yi, sx, sy, cx, cy;
        bit in_tex;
        texel_t t;
        in_tex = 1'b1;
        cx = s16(center[31:16]);
        cy = s16(center[15:0]);
        xi = longint'(p.x) - s16(origin[31:16]) + s16(scroll[31:16]) - cx;
        yi = longint'(p.y) - s16(origin[15:0]) + s16(scroll[15:0]) - cy;
        sx = (s16(mat_ab[31:16]) * xi + s16(mat_ab[15:0]) * yi + cx * 256) / 256;
        sy = (s16(mat_cd[31:16]) * xi + s16(mat_cd[15:0]) * yi + cy * 256) / 256;
        sx = fold(sx, clip_size(tex_size[21:11]), wrap, in_tex);
        sy = fold(sy, clip_size(tex_size[10:0]), wrap, in_tex);
        t.sx = in_tex ? sx[9:0] : '0;
        t.sy = in_tex ? sy[9:0] : '0;
        t.hit = in_tex;
        return t;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MATRIX_AB: mat_ab = val;
            REG_MATRIX_CD: mat_cd = val;
            REG_SCROLL_HV: scroll = val;
            REG_CENTER_XY: center = val;
            REG_ORIGIN_XY: origin = val;
            REG_TEX_SIZE:  tex_size = val[21:0];
            REG_WRAP_MODE: wrap = val[1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || expected_texels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic queue_pixel(logic [9:0] x, logic [9:0] y);
        pixel_t p;
        p.x = x;
        p.y = y;
        pending_pixels.push_back(p);
    endtask

    task automatic random_regs(bit wide);
        write_reg(REG_MATRIX_AB, wide ? $urandom : {8'($urandom_range(0, 3) - 2),
                  8'($urandom), 8'($urandom_range(0, 3) - 2), 8'($urandom)});
        write_reg(REG_MATRIX_CD, wide ? $urandom : {8'($urandom_range(0, 3) - 2),
                  8'($urandom), 8'($urandom_range(0, 3) - 2), 8'($urandom)});
        write_reg(REG_SCROLL_HV, wide ? $urandom : {16'($urandom_range(0, 600) - 300),
                  16'($urandom_range(0, 600) - 300)});
        write_reg(REG_CENTER_XY, wide ? $urandom : {16'($urandom_range(0, 512)),
                  16'($urandom_range(0, 512))});
        write_reg(REG_ORIGIN_XY, wide ? $urandom : {16'($urandom_range(0, 200) - 100),
                  16'($urandom_range(0, 200) - 100)});
        write_reg(REG_TEX_SIZE, $urandom_range(0, 3) == 0 ? $urandom :
                  32'({11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024))}));
        write_reg(REG_WRAP_MODE, $urandom_range(0, 3));
    endtask

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_texels.push_back(map_pixel(pixel_t'(s_axis_tdata[19:0])));
            void'(pending_pixels.pop_front());
        end
        if (in_gap > 0)
            in_gap <= in_gap - 1;
        else if (!calm && $urandom_range(0, 15) == 0)
            in_gap <= $urandom_range(1, 16);
        if (s_axis_tvalid && !s_axis_tready)
            s_axis_tvalid <= 1'b1;
        else if (pending_pixels.size() > 0 && in_gap == 0)
        begin
            s_axis_tdata <= {4'd0, pending_pixels[0]};
            s_axis_tvalid <= 1'b1;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    always @(posedge clk)
    begin
        texel_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_texels.size() == 0)
            begin
                $display("unexpected result item");
                errors++;
            end
            else
            begin
                want = expected_texels.pop_front();
                if (m_axis_tdata[9:0] != want.sx)
                    report_mismatch("src_x", m_axis_tdata[9:0], want.sx);
                if (m_axis_tdata[19:10] != want.sy)
                    report_mismatch("src_y", m_axis_tdata[19:10], want.sy);
                if (m_axis_tuser[0] != want.hit)
                    report_mismatch("hit", m_axis_tuser[0], want.hit);
            end
        end
        if (out_gap > 0)
        begin
            out_gap <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            out_gap <= $urandom_range(1, 16);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        mat_ab = 32'h0100_0000;
        mat_cd = 32'h0000_0100;
        scroll = '0;
        center = '0;
        origin = '0;
        tex_size = 22'd524544;
        wrap = WRAP_NONE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        queue_pixel(10'd0, 10'd0);
        queue_pixel(10'd1023, 10'd1023);
        queue_pixel(10'd255, 10'd255);
        queue_pixel(10'd256, 10'd3);
        queue_pixel(10'h2AA, 10'h155);
        queue_pixel(10'h155, 10'h2AA);
        drain();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_WRAP_MODE, 32'(m));
            write_reg(REG_MATRIX_AB, m[0] ? 32'h8000_7FFF : 32'hFF00_0080);
            write_reg(REG_MATRIX_CD, m[1] ? 32'h7FFF_8000 : 32'h0040_FF00);
            write_reg(REG_SCROLL_HV, m[0] ? 32'h8000_7FFF : 32'hFFF0_0010);
            write_reg(REG_CENTER_XY, m[1] ? 32'h7FFF_8000 : 32'h0080_0080);
            write_reg(REG_ORIGIN_XY, m[0] ? 32'hFFFF_FFFF : 32'h0010_FFF0);
            write_reg(REG_TEX_SIZE, m[1] ? 32'h003F_FFFF : 32'd0);
            queue_pixel(10'd0, 10'd1023);
            queue_pixel(10'd1023, 10'd0);
            queue_pixel(10'd512, 10'd512);
            queue_pixel(10'($urandom), 10'($urandom));
            drain();
        end
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        for (int phase = 0; phase < 10; phase++)
        begin
            random_regs(phase % 4 == 3);
            if (phase == 9) calm = 1'b1;
            repeat (100) queue_pixel(10'($urandom), 10'($urandom));
            drain();
        end
        if (errors == 0)
            $display("affine_texel_address_mapper_tb passed");
        else
            $display("affine_texel_address_mapper_tb failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("affine_texel_address_mapper_tb failed");
        $finish;
    end
endmodule
